// ===== rtl/adec_pkg.sv =====
// ----------------------------------------------------------------------------
// adec_pkg
// Shared types, register indexes and curve ROM builders for the axis
// deadzone / expo conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package adec_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_INNER  = 3'd0;
  localparam logic [2:0] REG_OUTER  = 3'd1;
  localparam logic [2:0] REG_EXPO   = 3'd2;
  localparam logic [2:0] REG_SENS   = 3'd3;
  localparam logic [2:0] REG_INVERT = 3'd4;

  // Flags that travel with a request through the divider
  typedef struct packed {
    logic        valid;
    logic        neg;
    logic        zero;
    logic        sat;
    logic [14:0] msat;
  } adec_side_t;

  // Fraction of log2(y/65536) in Q.16, resolved bit by bit by squaring
  function automatic logic [15:0] adec_frac_log2(input logic [16:0] y);
    logic [63:0] z;
    logic [15:0] r;
    z = {47'd0, y};
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      z = (z * z) >> 16;
      if (z >= 64'd131072) begin
        z = z >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  // Log ROM entry i for a table of 2^bits entries
  function automatic logic [15:0] adec_log_entry(input int i, input int bits);
    logic [16:0] y;
    y = 17'(65536 + (i << (16 - bits)));
    return adec_frac_log2(y);
  endfunction

  // Exp ROM entry: least y whose fractional log reaches the target
  function automatic logic [16:0] adec_exp_entry(input int i, input int bits);
    int lo;
    int hi;
    int mid;
    int target;
    lo = 65536;
    hi = 131071;
    target = i << (16 - bits);
    for (int it = 0; it < 18; it++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (int'(adec_frac_log2(17'(mid))) >= target) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
    end
    return 17'(lo);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/adec_div_pipe.sv =====
// ----------------------------------------------------------------------------
// adec_div_pipe
// Sixteen-stage restoring divider: (num << 16) / den, num below den,
// one quotient bit per register stage, flags carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module adec_div_pipe
  import adec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire adec_side_t  side_in,
  input  wire logic [14:0] num_in,
  input  wire logic [14:0] den_in,
  output adec_side_t       side_out,
  output logic [15:0]      quot_out
);

  localparam int Stages = 16;

  adec_side_t  side_r [Stages];
  logic [14:0] rem_r  [Stages];
  logic [14:0] den_r  [Stages];
  logic [15:0] q_r    [Stages];

  for (genvar j = 0; j < Stages; j++) begin : g_stage
    adec_side_t  side_prev;
    logic [14:0] rem_prev;
    logic [14:0] den_prev;
    logic [15:0] q_prev;
    logic [15:0] shifted;
    logic        ge;
    logic [14:0] rem_nxt;
    logic [15:0] q_nxt;

    if (j == 0) begin : g_first
      assign side_prev = side_in;
      assign rem_prev  = num_in;
      assign den_prev  = den_in;
      assign q_prev    = '0;
    end else begin : g_next
      assign side_prev = side_r[j-1];
      assign rem_prev  = rem_r[j-1];
      assign den_prev  = den_r[j-1];
      assign q_prev    = q_r[j-1];
    end

    // Trial subtract for one quotient bit
    always_comb begin
      shifted = {rem_prev, 1'b0};
      ge      = shifted >= {1'b0, den_prev};
      rem_nxt = ge ? 15'(shifted - {1'b0, den_prev}) : shifted[14:0];
      q_nxt   = {q_prev[14:0], ge};
    end

    // Advance the stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[j].valid <= 1'b0;
      end else begin
        side_r[j].valid <= side_prev.valid;
      end
      side_r[j].neg  <= side_prev.neg;
      side_r[j].zero <= side_prev.zero;
      side_r[j].sat  <= side_prev.sat;
      side_r[j].msat <= side_prev.msat;
      rem_r[j]       <= rem_nxt;
      den_r[j]       <= den_prev;
      q_r[j]         <= q_nxt;
    end
  end

  assign side_out = side_r[Stages-1];
  assign quot_out = q_r[Stages-1];

endmodule

`default_nettype wire

// ===== rtl/axis_deadzone_expo_conditioner_core.sv =====
// ----------------------------------------------------------------------------
// axis_deadzone_expo_conditioner_core
// Deadzone, saturation, expo curve and gain for one signed axis sample.
// ----------------------------------------------------------------------------
// Pipeline from start to out_valid: entry stage, 16 divider stages, five
// curve stages, output register.
// Throughput: one request per cycle; busy is always low, the result cannot
// be stalled. The pipeline depth is set by the bit-per-stage divider.
// Reset clears the pipeline valid bits and loads the register defaults.
`default_nettype none

module axis_deadzone_expo_conditioner_core
  import adec_pkg::*;
#(
  parameter int CURVE_TABLE_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_raw_sample,
  output logic             out_valid,
  output logic [15:0]      out_tuned_value,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int Entries = 1 << CURVE_TABLE_BITS;

  // Curve ROMs built at elaboration
  logic [15:0] log_rom [Entries];
  logic [16:0] exp_rom [Entries];
  for (genvar i = 0; i < Entries; i++) begin : g_rom
    localparam logic [15:0] LogVal = adec_log_entry(i, CURVE_TABLE_BITS);
    localparam logic [16:0] ExpVal = adec_exp_entry(i, CURVE_TABLE_BITS);
    assign log_rom[i] = LogVal;
    assign exp_rom[i] = ExpVal;
  end

  // Configuration registers
  logic [14:0] inner_r;
  logic [14:0] outer_r;
  logic [15:0] expo_r;
  logic [15:0] sens_r;
  logic        invert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r  <= 15'd0;
      outer_r  <= 15'd32767;
      expo_r   <= 16'd4096;
      sens_r   <= 16'd4096;
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INNER:  inner_r  <= cfg_wdata[14:0];
        REG_OUTER:  outer_r  <= cfg_wdata[14:0];
        REG_EXPO:   expo_r   <= cfg_wdata;
        REG_SENS:   sens_r   <= cfg_wdata;
        REG_INVERT: invert_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Entry: magnitude, limits and the saturated value
  adec_side_t  side_nxt;
  logic [16:0] mag;
  logic [14:0] outer_eff;
  logic [30:0] sat_prod;
  logic [14:0] num_nxt;
  logic [14:0] den_nxt;

  always_comb begin
    mag       = in_raw_sample[15] ? 17'(17'h10000 - {1'b0, in_raw_sample})
                                  : {1'b0, in_raw_sample};
    outer_eff = (outer_r > inner_r) ? outer_r : 15'd32767;
    sat_prod  = {sens_r, 15'd0} - {15'd0, sens_r};
    side_nxt.valid = start;
    side_nxt.neg   = in_raw_sample[15];
    side_nxt.zero  = mag <= {2'b0, inner_r};
    side_nxt.sat   = mag >= {2'b0, outer_eff};
    side_nxt.msat  = (sat_prod[30:12] > 19'd32767) ? 15'd32767 : sat_prod[26:12];
    num_nxt = 15'(mag - {2'b0, inner_r});
    den_nxt = outer_eff - inner_r;
  end

  adec_side_t  s0_side_r;
  logic [14:0] s0_num_r;
  logic [14:0] s0_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_side_r.valid <= 1'b0;
    end else begin
      s0_side_r.valid <= side_nxt.valid;
    end
    s0_side_r.neg  <= side_nxt.neg;
    s0_side_r.zero <= side_nxt.zero;
    s0_side_r.sat  <= side_nxt.sat;
    s0_side_r.msat <= side_nxt.msat;
    s0_num_r       <= num_nxt;
    s0_den_r       <= den_nxt;
  end

  // Normalise the span position to Q0.16
  adec_side_t  dv_side;
  logic [15:0] dv_quot;

  adec_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .side_in  (s0_side_r),
    .num_in   (s0_num_r),
    .den_in   (s0_den_r),
    .side_out (dv_side),
    .quot_out (dv_quot)
  );

  // Stage A: leading one and table index
  logic [3:0]  lead_pos;
  logic [15:0] x_norm;
  adec_side_t  sa_side_r;
  logic [3:0]  sa_pos_r;
  logic [CURVE_TABLE_BITS-1:0] sa_idx_r;

  always_comb begin
    lead_pos = 4'd0;
    for (int b = 1; b < 16; b++) begin
      if (dv_quot[b]) begin
        lead_pos = 4'(b);
      end
    end
    x_norm = dv_quot << (4'd15 - lead_pos);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_side_r.valid <= 1'b0;
    end else begin
      sa_side_r.valid <= dv_side.valid;
    end
    sa_side_r.neg  <= dv_side.neg;
    sa_side_r.zero <= dv_side.zero;
    sa_side_r.sat  <= dv_side.sat;
    sa_side_r.msat <= dv_side.msat;
    sa_pos_r       <= lead_pos;
    sa_idx_r       <= x_norm[14 -: CURVE_TABLE_BITS];
  end

  // Stage B: minus log2 of x in Q.16
  logic [4:0]  int_part;
  logic [20:0] nlog_nxt;
  adec_side_t  sb_side_r;
  logic [20:0] sb_nlog_r;

  always_comb begin
    int_part = 5'd16 - {1'b0, sa_pos_r};
    nlog_nxt = {int_part, 16'd0} - {5'd0, log_rom[sa_idx_r]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_side_r.valid <= 1'b0;
    end else begin
      sb_side_r.valid <= sa_side_r.valid;
    end
    sb_side_r.neg  <= sa_side_r.neg;
    sb_side_r.zero <= sa_side_r.zero;
    sb_side_r.sat  <= sa_side_r.sat;
    sb_side_r.msat <= sa_side_r.msat;
    sb_nlog_r      <= nlog_nxt;
  end

  // Stage C: scale by the exponent
  logic [36:0] expo_prod;
  adec_side_t  sc_side_r;
  logic [24:0] sc_t_r;

  assign expo_prod = sb_nlog_r * expo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_side_r.valid <= 1'b0;
    end else begin
      sc_side_r.valid <= sb_side_r.valid;
    end
    sc_side_r.neg  <= sb_side_r.neg;
    sc_side_r.zero <= sb_side_r.zero;
    sc_side_r.sat  <= sb_side_r.sat;
    sc_side_r.msat <= sb_side_r.msat;
    sc_t_r         <= expo_prod[36:12];
  end

  // Stage D: exp2 of the negated product
  logic [15:0] frac_part;
  logic [15:0] frac_neg;
  logic [9:0]  shift_amt;
  logic [16:0] y_nxt;
  adec_side_t  sd_side_r;
  logic [16:0] sd_y_r;

  always_comb begin
    frac_part = sc_t_r[15:0];
    frac_neg  = 16'(17'h10000 - {1'b0, frac_part});
    shift_amt = {1'b0, sc_t_r[24:16]} + {9'd0, (frac_part != 16'd0)};
    if (shift_amt > 10'd17) begin
      y_nxt = 17'd0;
    end else begin
      y_nxt = exp_rom[frac_neg[15 -: CURVE_TABLE_BITS]] >> shift_amt[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_side_r.valid <= 1'b0;
    end else begin
      sd_side_r.valid <= sc_side_r.valid;
    end
    sd_side_r.neg  <= sc_side_r.neg;
    sd_side_r.zero <= sc_side_r.zero;
    sd_side_r.sat  <= sc_side_r.sat;
    sd_side_r.msat <= sc_side_r.msat;
    sd_y_r         <= y_nxt;
  end

  // Stage E: gain and clamp to 1.0
  logic [32:0] gain_prod;
  adec_side_t  se_side_r;
  logic [16:0] se_g_r;

  assign gain_prod = sd_y_r * sens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      se_side_r.valid <= 1'b0;
    end else begin
      se_side_r.valid <= sd_side_r.valid;
    end
    se_side_r.neg  <= sd_side_r.neg;
    se_side_r.zero <= sd_side_r.zero;
    se_side_r.sat  <= sd_side_r.sat;
    se_side_r.msat <= sd_side_r.msat;
    se_g_r <= (gain_prod[32:12] > 21'd65536) ? 17'd65536 : gain_prod[28:12];
  end

  // Output: full-scale multiply, select, restore sign
  logic [31:0] scale_prod;
  logic [14:0] mag_out;
  logic [15:0] val_nxt;
  logic        valid_r;
  logic [15:0] value_r;

  always_comb begin
    scale_prod = {se_g_r, 15'd0} - {15'd0, se_g_r};
    if (se_side_r.zero) begin
      mag_out = 15'd0;
    end else if (se_side_r.sat) begin
      mag_out = se_side_r.msat;
    end else begin
      mag_out = scale_prod[30:16];
    end
    val_nxt = (se_side_r.neg ^ invert_r) ? 16'(17'h10000 - {2'b0, mag_out})
                                         : {1'b0, mag_out};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= se_side_r.valid;
    end
    value_r <= val_nxt;
  end

  assign out_valid       = valid_r;
  assign out_tuned_value = value_r;

endmodule

`default_nettype wire
